[hdl/sha256_pkg.sv]
// types and constants for the sha-256 byte stream hasher
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} sha_out_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
				6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
				6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
				6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
				6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
				6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
				6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
				6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
				6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
				6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
				6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
				6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
				6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
				6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
				6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
				6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
				6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
				6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
				6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
				6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
				6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
				6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

[hdl/sha256_byte_stream_hasher.sv]
// sha-256 byte stream hasher top level
// Bytes are taken one per cycle into a 64-byte block memory (16 words of 32 bits); a full
// block is then compressed by one round per cycle, 64 rounds, with the message schedule
// read from and written back to the same 16-word memory, so input stalls while each block
// is loaded, put through its 64 rounds and added. At the end mark the block is padded
// one word per cycle, compressed once or twice, and the eight digest words are delivered
// as eight items, H0 first.
module sha256_byte_stream_hasher
	import sha256_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  sha_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output sha_out_t out_data
);

	typedef enum logic [6:0] {
		ST_FILL  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_LEN   = 7'b0000100,
		ST_LOAD  = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_ADD   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [31:0] w_mem [16];
	logic [31:0] hw_q [8];
	logic [31:0] wk_q [8];
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [6:0]  rnd_q;
	logic [31:0] cur_word_q;
	logic        final_q;
	logic        second_q;
	logic [2:0]  out_idx_q;
	// length block still owed: pad ran past offset 56 and went straight to compress
	logic        lenpend_q;

	// schedule read ports (registered)
	logic [31:0] rd_w_q, rd_w1_q, rd_w9_q, rd_w14_q;
	logic [31:0] wt, s0, s1, t1, t2;
	logic [31:0] new_word;
	logic        in_acc, out_acc;
	logic [5:0]  r6;
	logic [3:0]  ra;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != ST_FILL);
	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = hw_q[out_idx_q];
	assign out_data.word_number = out_idx_q;
	assign out_data.last_word = (out_idx_q == 3'd7);

	assign r6 = rnd_q[5:0];
	assign ra = r6[3:0];

	// byte merge into the current big-endian word
	always_comb begin
		new_word = cur_word_q;
		case (fill_q[1:0])
			2'd0: new_word = {in_data.data_byte, 24'd0};
			2'd1: new_word[23:16] = in_data.data_byte;
			2'd2: new_word[15:8] = in_data.data_byte;
			default: new_word[7:0] = in_data.data_byte;
		endcase
	end

	// round logic; rd_w_q holds w[i mod 16] for rounds <16, else computed
	always_comb begin
		s0 = rotr(rd_w1_q, 7) ^ rotr(rd_w1_q, 18) ^ (rd_w1_q >> 3);
		s1 = rotr(rd_w14_q, 17) ^ rotr(rd_w14_q, 19) ^ (rd_w14_q >> 10);
		wt = (rnd_q < 7'd16) ? rd_w_q : (rd_w_q + s0 + rd_w9_q + s1);
		t1 = wk_q[7] + (rotr(wk_q[4], 6) ^ rotr(wk_q[4], 11) ^ rotr(wk_q[4], 25))
			+ ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6])) + round_k(r6) + wt;
		t2 = (rotr(wk_q[0], 2) ^ rotr(wk_q[0], 13) ^ rotr(wk_q[0], 22))
			+ ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));
	end

	// schedule memory: writes from fill, pad, length and rounds; four registered reads
	logic        mem_we;
	logic [3:0]  mem_wa, rda;
	logic [31:0] mem_wd;
	logic [6:0]  nxt;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q[5:2];
		mem_wd = new_word;
		nxt = rnd_q + 7'd1;
		rda = nxt[3:0];
		unique case (state_q)
			ST_FILL: mem_we = in_acc && in_data.byte_present;
			ST_PAD, ST_LEN: mem_we = 1'b1;
			ST_ROUND: begin
				mem_we = 1'b1;
				mem_wa = ra;
				mem_wd = wt;
			end
			ST_LOAD: rda = 4'd0;
			default: ;
		endcase
		if (state_q == ST_PAD) mem_wd = cur_word_q;
		if (state_q == ST_LEN)
			mem_wd = fill_q[2] ? {count_q[28:0], 3'd0} : count_q[60:29];
	end

	always_ff @(posedge clk) begin
		if (mem_we) w_mem[mem_wa] <= mem_wd;
		// forward the word being written this cycle
		rd_w_q   <= (mem_we && mem_wa == rda) ? mem_wd : w_mem[rda];
		rd_w1_q  <= (mem_we && mem_wa == rda + 4'd1) ? mem_wd : w_mem[rda + 4'd1];
		rd_w9_q  <= (mem_we && mem_wa == rda + 4'd9) ? mem_wd : w_mem[rda + 4'd9];
		rd_w14_q <= (mem_we && mem_wa == rda + 4'd14) ? mem_wd : w_mem[rda + 4'd14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= '0;
			count_q <= '0;
			rnd_q <= '0;
			final_q <= 1'b0;
			second_q <= 1'b0;
			out_idx_q <= '0;
			cur_word_q <= '0;
			for (int i = 0; i < 8; i++) hw_q[i] <= INIT_H[i];
			for (int i = 0; i < 8; i++) wk_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (in_acc) begin
						if (in_data.byte_present) begin
							cur_word_q <= new_word;
							fill_q <= fill_q + 6'd1;
							count_q <= count_q + 61'd1;
						end
						final_q <= in_data.end_of_message;
						if (in_data.byte_present && fill_q == 6'd63)
							state_q <= ST_LOAD;
						else if (in_data.end_of_message)
							state_q <= ST_PAD;
						if (in_data.end_of_message) second_q <= 1'b0;
					end
				end
				ST_PAD: begin
					// first pad cycle appends 0x80, later ones write zero words
					if (!second_q) begin
						second_q <= 1'b1;
						case (fill_q[1:0])
							2'd0: cur_word_q <= {PAD_BYTE, 24'd0};
							2'd1: cur_word_q <= {cur_word_q[31:24], PAD_BYTE, 16'd0};
							2'd2: cur_word_q <= {cur_word_q[31:16], PAD_BYTE, 8'd0};
							default: cur_word_q <= {cur_word_q[31:8], PAD_BYTE};
						endcase
						fill_q <= {fill_q[5:2], 2'd0};
					end else begin
						fill_q <= fill_q + 6'd4;
						cur_word_q <= '0;
						if (fill_q == 6'd60) state_q <= ST_LOAD;
						else if (fill_q == LEN_OFFSET - 6'd4) state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					fill_q <= fill_q + 6'd4;
					if (fill_q == 6'd60) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					for (int i = 0; i < 8; i++) wk_q[i] <= hw_q[i];
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					wk_q[7] <= wk_q[6]; wk_q[6] <= wk_q[5]; wk_q[5] <= wk_q[4];
					wk_q[4] <= wk_q[3] + t1;
					wk_q[3] <= wk_q[2]; wk_q[2] <= wk_q[1]; wk_q[1] <= wk_q[0];
					wk_q[0] <= t1 + t2;
					rnd_q <= nxt;
					if (rnd_q == 7'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hw_q[i] <= hw_q[i] + wk_q[i];
					fill_q <= '0;
					cur_word_q <= '0;
					if (!final_q) state_q <= ST_FILL;
					else if (!second_q) state_q <= ST_PAD;
					else state_q <= (lenpend_q ? ST_PAD : ST_OUT);
					out_idx_q <= '0;
				end
				ST_OUT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q <= ST_FILL;
							fill_q <= '0;
							count_q <= '0;
							final_q <= 1'b0;
							for (int i = 0; i < 8; i++) hw_q[i] <= INIT_H[i];
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lenpend_q <= 1'b0;
		else if (state_q == ST_PAD && second_q && fill_q == 6'd60) lenpend_q <= 1'b1;
		else if (state_q == ST_PAD && second_q && fill_q == LEN_OFFSET - 6'd4)
			lenpend_q <= 1'b0;
		else if (state_q == ST_OUT) lenpend_q <= 1'b0;
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> in_stall)
		else $error("input taken during rounds");
	a_round_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd_q == 7'd63 |=> state_q == ST_ADD)
		else $error("round count lost");
	a_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_data.last_word |=> state_q == ST_FILL)
		else $error("no restart after digest");

endmodule
